// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MBRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define MBRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/mbrx_pkg.sv
// types, constants and the crc byte step of the modbus rtu frame receiver
package mbrx_pkg;

    localparam int unsigned FRAME_MAX_DEF = 256;
    localparam int unsigned POS_W         = 9;
    localparam int unsigned LEN_W         = 18;
    localparam int unsigned FIFO_DEPTH    = 2;
    localparam int unsigned PTR_W         = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W         = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]       ADDR_RESET  = 8'h01;
    localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY    = 16'hA001;
    localparam logic [POS_W-1:0] FIXED_LEN   = 9'd8;
    localparam logic [LEN_W-1:0] MULTI_BASE  = 18'd9;
    localparam logic [POS_W-1:0] POS_FC      = 9'd1;
    localparam logic [POS_W-1:0] POS_QTY_HI  = 9'd4;
    localparam logic [POS_W-1:0] POS_QTY_LO  = 9'd5;

    localparam logic [7:0] FC_READ_HOLD    = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    typedef enum logic {
        KIND_BYTE,
        KIND_GAP
    } t_kind;

    typedef enum logic [1:0] {
        FCC_NONE,
        FCC_FIXED,
        FCC_MULTI
    } t_fc_class;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_GAP_ABORT = 3'd4
    } t_status;

    typedef struct packed {
        t_kind      kind;
        t_fc_class  fc;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] mbrx_crc_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/mbrx_fifo.sv
// two-entry queue between the classifying front and the frame back end
module mbrx_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbrx_pkg::t_item i_item,
    input  logic            i_pop,
    output mbrx_pkg::t_item o_item,
    output mbrx_pkg::t_q_stat o_stat
);
    import mbrx_pkg::*;

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: rtl/mbrx_front.sv
// input side: takes beats and classifies them before queuing
module mbrx_front (
    input  logic              i_valid,
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  mbrx_pkg::t_q_stat i_q_stat,
    output logic              o_stall,
    output logic              o_push,
    output mbrx_pkg::t_item   o_item
);
    import mbrx_pkg::*;

    t_fc_class fc;

    always_comb begin
        unique case (i_rx_byte) inside
            FC_READ_HOLD, FC_WRITE_SINGLE: fc = FCC_FIXED;
            FC_WRITE_MULTI:                fc = FCC_MULTI;
            default:                       fc = FCC_NONE;
        endcase
    end

    assign o_stall     = i_q_stat.full;
    assign o_push      = i_valid && !i_q_stat.full;
    assign o_item.kind = i_cmd ? KIND_GAP : KIND_BYTE;
    assign o_item.fc   = fc;
    assign o_item.data = i_rx_byte;

endmodule

// File: rtl/mbrx_back.sv
// frame tracking, running crc and the output register
module mbrx_back #(
    parameter int unsigned FRAME_MAX = mbrx_pkg::FRAME_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_slave_address,
    input  mbrx_pkg::t_q_stat i_q_stat,
    input  mbrx_pkg::t_item   i_item,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_frame_byte,
    output logic [7:0]        o_byte_index,
    output logic              o_last,
    output logic [2:0]        o_frame_status
);
    import mbrx_pkg::*;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_MAX);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] r_exp;
    logic [POS_W-1:0] n_exp;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic             r_multi;
    logic             n_multi;
    logic [7:0]       r_qty_hi;
    logic [7:0]       n_qty_hi;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       r_out_index;
    logic             r_out_last;
    t_status          r_out_status;

    logic             res_valid;
    logic [7:0]       res_byte;
    logic             res_last;
    t_status          res_status;

    logic [15:0]      crc_next;
    logic [LEN_W-1:0] len_multi;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] exp_sel;
    logic             take;
    logic             hunt;

    assign o_pop     = !i_q_stat.empty && (!r_out_valid || !i_stall);
    assign crc_next  = mbrx_crc_byte(r_crc, i_item.data);
    assign len_multi = MULTI_BASE + {1'b0, r_qty_hi, i_item.data, 1'b0};
    assign pos_inc   = r_pos + POS_W'(1);

    always_comb begin
        n_pos      = r_pos;
        n_exp      = r_exp;
        n_crc      = r_crc;
        n_multi    = r_multi;
        n_qty_hi   = r_qty_hi;
        res_valid  = 1'b0;
        res_byte   = i_item.data;
        res_last   = 1'b0;
        res_status = ST_BUSY;
        exp_sel    = r_exp;
        take       = 1'b0;
        hunt       = 1'b0;

        if (i_item.kind == KIND_GAP) begin
            if (r_pos != '0) begin
                res_valid  = 1'b1;
                res_byte   = 8'h00;
                res_last   = 1'b1;
                res_status = ST_GAP_ABORT;
                hunt       = 1'b1;
            end
        end else if (r_pos == '0) begin
            take = (i_item.data == i_slave_address);
        end else if (r_pos == POS_FC) begin
            case (i_item.fc)
                FCC_FIXED: begin
                    exp_sel = FIXED_LEN;
                    n_multi = 1'b0;
                    take    = 1'b1;
                end
                FCC_MULTI: begin
                    exp_sel = '0;
                    n_multi = 1'b1;
                    take    = 1'b1;
                end
                default: begin
                    hunt = 1'b1;
                end
            endcase
        end else if (r_multi && r_pos == POS_QTY_HI) begin
            n_qty_hi = i_item.data;
            take     = 1'b1;
        end else if (r_multi && r_pos == POS_QTY_LO) begin
            if (len_multi > LEN_LIMIT) begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = ST_TOO_LONG;
                hunt       = 1'b1;
            end else begin
                exp_sel = len_multi[POS_W-1:0];
                take    = 1'b1;
            end
        end else begin
            take = 1'b1;
        end

        if (take) begin
            res_valid = 1'b1;
            n_crc     = crc_next;
            n_pos     = pos_inc;
            n_exp     = exp_sel;
            if (exp_sel != '0 && pos_inc >= exp_sel) begin
                res_last   = 1'b1;
                res_status = (crc_next == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
                hunt       = 1'b1;
            end
        end

        if (hunt) begin
            n_pos    = '0;
            n_exp    = '0;
            n_crc    = CRC_INIT;
            n_multi  = 1'b0;
            n_qty_hi = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_exp       <= '0;
            r_crc       <= CRC_INIT;
            r_multi     <= 1'b0;
            r_qty_hi    <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos       <= n_pos;
                r_exp       <= n_exp;
                r_crc       <= n_crc;
                r_multi     <= n_multi;
                r_qty_hi    <= n_qty_hi;
                r_out_valid <= res_valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_out_byte   <= res_byte;
            r_out_index  <= r_pos[7:0];
            r_out_last   <= res_last;
            r_out_status <= res_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_byte   = r_out_byte;
    assign o_byte_index   = r_out_index;
    assign o_last         = r_out_last;
    assign o_frame_status = r_out_status;

endmodule

// File: rtl/modbus_rtu_frame_receiver_unit.sv
// Modbus RTU request frame receiver: finds frames addressed to this slave in a
// byte stream, echoes each frame byte with its index and checks the CRC-16.
// A beat is taken every cycle while the two-entry input queue has room; the
// frame tracker and its byte-wide CRC step handle one queued beat per cycle
// unless the result side stalls, which sets the sustained rate. Each accepted
// beat is queued and its result is registered in the output register when
// the tracker takes it. A result-side stall backs up into the queue; the input
// stalls while the queue holds two beats. A gap beat aborts a partial frame
// with an incomplete status. The slave address register resets to 1; the user
// must write it only while the block is idle, which the block does not enforce.
module modbus_rtu_frame_receiver_unit #(
    parameter int unsigned FRAME_MAX = mbrx_pkg::FRAME_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic [7:0] o_byte_index,
    output logic       o_last,
    output logic [2:0] o_frame_status
);
    import mbrx_pkg::*;

    logic [7:0] r_slave_address;
    logic       push;
    logic       pop;
    t_item      front_item;
    t_item      queue_item;
    t_q_stat    q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= ADDR_RESET;
        end else if (i_cfg_we) begin
            r_slave_address <= i_cfg_wdata;
        end
    end

    mbrx_front u_front (
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_item    (front_item)
    );

    mbrx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (q_stat)
    );

    mbrx_back #(
        .FRAME_MAX (FRAME_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (r_slave_address),
        .i_q_stat        (q_stat),
        .i_item          (queue_item),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_frame_byte    (o_frame_byte),
        .o_byte_index    (o_byte_index),
        .o_last          (o_last),
        .o_frame_status  (o_frame_status)
    );

endmodule

// File: rtl/mbrx_checker.sv
// port-level checks of the frame receiver and their bind to the top level
`include "assert_macros.svh"

module mbrx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_cmd,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic [7:0] o_byte_index,
    input logic       o_last,
    input logic [2:0] o_frame_status
);
    import mbrx_pkg::*;

    // stalled input beat holds
    `MBRX_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_cmd) && $stable(i_rx_byte))

    // stalled result beat holds
    `MBRX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_frame_byte) && $stable(o_byte_index) && $stable(o_last) && $stable(o_frame_status))

    // a final status comes exactly with the last beat
    `MBRX_ASSERT_IMP(a_last_status, i_clk, i_rst_n, o_valid, o_last == (o_frame_status != ST_BUSY))

    // gap abort carries a zero byte
    `MBRX_ASSERT_IMP(a_gap_zero, i_clk, i_rst_n, o_valid && o_frame_status == ST_GAP_ABORT, o_frame_byte == 8'h00)

    // length overflow is only found on the low quantity byte
    `MBRX_ASSERT_IMP(a_too_long_idx, i_clk, i_rst_n, o_valid && o_frame_status == ST_TOO_LONG, o_byte_index == POS_QTY_LO[7:0])

endmodule

bind modbus_rtu_frame_receiver_unit mbrx_checker u_checker (.*);

// File: test/tb.sv
// testbench for the modbus rtu frame receiver: directed table, then random frames
module tb;
    import mbrx_pkg::*;

    localparam int unsigned FRAME_LIMIT = FRAME_MAX_DEF;
    localparam int unsigned PHASE_BEATS = 70;

    typedef struct packed {
        logic [7:0] fbyte;
        logic [7:0] idx;
        logic       last;
        t_status    status;
    } t_frame_beat;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_GAP,
        ROW_CRC_LO,
        ROW_CRC_HI
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        typed;
        logic        t_has;
        t_frame_beat t_res;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       i_valid;
    logic       o_stall;
    logic       i_cmd;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_frame_byte;
    logic [7:0] o_byte_index;
    logic       o_last;
    logic [2:0] o_frame_status;

    logic [7:0]  slave_addr_q;
    logic [8:0]  trk_pos;
    logic [8:0]  trk_len;
    logic [15:0] trk_crc;
    logic [7:0]  trk_fc;
    logic [7:0]  trk_qty_hi;

    t_frame_beat pending[$];
    t_stim_row   dir_rows[$];
    int unsigned err_count;
    int unsigned checked_beats;
    int unsigned result_beats;
    bit          idle_on;
    bit          hold_req;

    modbus_rtu_frame_receiver_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_frame_byte  (o_frame_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last),
        .o_frame_status(o_frame_status)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    function automatic void go_hunt();
        trk_pos    = '0;
        trk_len    = '0;
        trk_crc    = 16'hFFFF;
        trk_fc     = '0;
        trk_qty_hi = '0;
    endfunction

    function automatic bit step_tracker(input t_kind k, input logic [7:0] b,
                                        output t_frame_beat r);
        logic [8:0]  idx;
        logic [17:0] len;
        r = '0;
        if (k == KIND_GAP) begin
            if (trk_pos == 9'd0) return 0;
            r.fbyte  = 8'h00;
            r.idx    = trk_pos[7:0];
            r.last   = 1'b1;
            r.status = ST_GAP_ABORT;
            go_hunt();
            return 1;
        end
        if (trk_pos == 9'd0) begin
            if (b != slave_addr_q) return 0;
        end else if (trk_pos == POS_FC) begin
            if (b == FC_READ_HOLD || b == FC_WRITE_SINGLE) begin
                trk_len = 9'd8;
            end else if (b == FC_WRITE_MULTI) begin
                trk_len = 9'd0;
            end else begin
                go_hunt();
                return 0;
            end
            trk_fc = b;
        end else if (trk_fc == FC_WRITE_MULTI && trk_pos == POS_QTY_HI) begin
            trk_qty_hi = b;
        end else if (trk_fc == FC_WRITE_MULTI && trk_pos == POS_QTY_LO) begin
            len = 18'd9 + {1'b0, trk_qty_hi, b, 1'b0};
            if (len > FRAME_LIMIT) begin
                r.fbyte  = b;
                r.idx    = trk_pos[7:0];
                r.last   = 1'b1;
                r.status = ST_TOO_LONG;
                go_hunt();
                return 1;
            end
            trk_len = len[8:0];
        end
        idx     = trk_pos;
        trk_crc = crc16_step(trk_crc, b);
        trk_pos = trk_pos + 9'd1;
        r.fbyte  = b;
        r.idx    = idx[7:0];
        r.status = ST_BUSY;
        if (trk_len != 9'd0 && trk_pos >= trk_len) begin
            r.last   = 1'b1;
            r.status = (trk_crc == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
            go_hunt();
        end
        return 1;
    endfunction

    function automatic bit queue_expected(input t_kind k, input logic [7:0] b);
        t_frame_beat r;
        if (!step_tracker(k, b, r)) return 0;
        pending.push_back(r);
        return 1;
    endfunction

    function automatic t_stim_row row_pred(input t_row_kind k, input logic [7:0] d);
        t_stim_row s;
        s      = '0;
        s.kind = k;
        s.data = d;
        return s;
    endfunction

    function automatic t_stim_row row_typed(input t_row_kind k, input logic [7:0] d,
                                            input logic has, input logic [7:0] fb,
                                            input logic [7:0] ix, input logic lst,
                                            input t_status st);
        t_stim_row s;
        s              = '0;
        s.kind         = k;
        s.data         = d;
        s.typed        = 1'b1;
        s.t_has        = has;
        s.t_res.fbyte  = fb;
        s.t_res.idx    = ix;
        s.t_res.last   = lst;
        s.t_res.status = st;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        if (err_count <= 100)
            $display("result beat %0d %s: got %0h want %0h", checked_beats, what, got, want);
    endtask

    task automatic check_beat();
        t_frame_beat want;
        checked_beats++;
        if (pending.size() == 0) begin
            report_mismatch("result with none pending", {o_byte_index, o_frame_byte}, 16'h0);
            return;
        end
        want = pending.pop_front();
        if (o_frame_byte !== want.fbyte)
            report_mismatch("frame_byte", 16'(o_frame_byte), 16'(want.fbyte));
        if (o_byte_index !== want.idx)
            report_mismatch("byte_index", 16'(o_byte_index), 16'(want.idx));
        if (o_last !== want.last)
            report_mismatch("last", 16'(o_last), 16'(want.last));
        if (o_frame_status !== want.status)
            report_mismatch("frame_status", 16'(o_frame_status), 16'(want.status));
    endtask

    task automatic offer_beat(input t_kind k, input logic [7:0] d);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= k;
        i_rx_byte <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_item(input t_kind k, input logic [7:0] d);
        if (queue_expected(k, d)) result_beats++;
        offer_beat(k, d);
    endtask

    task automatic wait_results();
        int unsigned n;
        n = 0;
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending.size() != 0 && n < 20000);
    endtask

    task automatic write_address(input logic [7:0] a);
        wait_results();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        slave_addr_q  = a;
    endtask

    task automatic send_frame(input bit force_max);
        logic [7:0]  body[$];
        logic [7:0]  fc;
        logic [15:0] qty;
        logic [15:0] crc;
        int unsigned roll;
        int unsigned n_data;
        int unsigned cut;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        else if (roll < 18)
            send_item(KIND_GAP, 8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (force_max) fc = FC_WRITE_MULTI;
        else if (roll < 30) fc = FC_READ_HOLD;
        else if (roll < 55) fc = FC_WRITE_SINGLE;
        else if (roll < 90) fc = FC_WRITE_MULTI;
        else fc = 8'($urandom_range(0, 255));
        body.push_back(($urandom_range(0, 19) == 0 && !force_max) ?
                       8'($urandom_range(0, 255)) : slave_addr_q);
        body.push_back(fc);
        n_data = 4;
        if (fc == FC_WRITE_MULTI) begin
            roll = $urandom_range(0, 99);
            if (force_max) qty = 16'((FRAME_LIMIT - 9) / 2);
            else if (roll < 80) qty = 16'($urandom_range(0, 6));
            else if (roll < 88) qty = 16'((FRAME_LIMIT - 9) / 2 + 1);
            else qty = 16'($urandom_range(0, 65535));
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(qty[15:8]);
            body.push_back(qty[7:0]);
            n_data = (9 + 2 * int'(qty) <= FRAME_LIMIT) ? 1 + 2 * int'(qty) :
                     $urandom_range(0, 4);
        end
        repeat (n_data) body.push_back(8'($urandom_range(0, 255)));
        crc = 16'hFFFF;
        foreach (body[i]) crc = crc16_step(crc, body[i]);
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if ($urandom_range(0, 9) == 0)
            body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
        cut = body.size();
        if (!force_max && $urandom_range(0, 11) == 0)
            cut = $urandom_range(1, body.size() - 1);
        for (int i = 0; i < cut; i++) send_item(KIND_BYTE, body[i]);
        if (cut < body.size()) send_item(KIND_GAP, 8'($urandom_range(0, 255)));
    endtask

    // receiver side: checks each beat and drives stall
    initial begin : sink
        int unsigned burst;
        int unsigned hold_cnt;
        burst    = 0;
        hold_cnt = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_beat();
            if (hold_cnt != 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
                if (hold_cnt == 0) hold_req = 1'b0;
            end else if (hold_req) begin
                hold_cnt = 64;
                i_stall <= 1'b1;
            end else if (burst != 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_stim_row   row;
        t_frame_beat scratch;
        t_kind       kind;
        logic [7:0]  d;
        logic [7:0]  crc_hi_next;
        logic [7:0]  addr;
        int unsigned start;
        bit          paused;
        err_count     = 0;
        checked_beats = 0;
        result_beats  = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        crc_hi_next   = '0;
        slave_addr_q  = ADDR_RESET;
        go_hunt();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_cmd       <= 1'b0;
        i_rx_byte   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset address is 1
        dir_rows.push_back(row_typed(ROW_GAP,  8'h00, 1'b0, 8'h00, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h55, 1'b0, 8'h00, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h01, 1'b1, 8'h01, 8'd0, 1'b0, ST_BUSY));
        // unsupported function code equal to the address is not taken as a new start
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h01, 1'b0, 8'h00, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h01, 1'b1, 8'h01, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, FC_WRITE_SINGLE, 1'b1, FC_WRITE_SINGLE, 8'd1,
                                     1'b0, ST_BUSY));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h00));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'hFF));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h12));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h34));
        dir_rows.push_back(row_pred(ROW_CRC_LO, 8'h00));
        dir_rows.push_back(row_pred(ROW_CRC_HI, 8'h00));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h01, 1'b1, 8'h01, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, FC_WRITE_MULTI, 1'b1, FC_WRITE_MULTI, 8'd1,
                                     1'b0, ST_BUSY));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h00));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h01));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'hFF));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'hFF, 1'b1, 8'hFF, 8'd5, 1'b1, ST_TOO_LONG));
        dir_rows.push_back(row_typed(ROW_BYTE, 8'h01, 1'b1, 8'h01, 8'd0, 1'b0, ST_BUSY));
        dir_rows.push_back(row_typed(ROW_BYTE, FC_READ_HOLD, 1'b1, FC_READ_HOLD, 8'd1,
                                     1'b0, ST_BUSY));
        dir_rows.push_back(row_pred(ROW_BYTE, 8'h00));
        dir_rows.push_back(row_typed(ROW_GAP,  8'hA5, 1'b1, 8'h00, 8'd3, 1'b1, ST_GAP_ABORT));
        dir_rows.push_back(row_typed(ROW_GAP,  8'h5A, 1'b0, 8'h00, 8'd0, 1'b0, ST_BUSY));

        foreach (dir_rows[i]) begin
            row  = dir_rows[i];
            d    = row.data;
            kind = (row.kind == ROW_GAP) ? KIND_GAP : KIND_BYTE;
            if (row.kind == ROW_CRC_LO) begin
                d           = trk_crc[7:0];
                crc_hi_next = trk_crc[15:8];
            end else if (row.kind == ROW_CRC_HI) begin
                d = crc_hi_next;
            end
            if (row.typed) begin
                void'(step_tracker(kind, d, scratch));
                if (row.t_has) pending.push_back(row.t_res);
            end else begin
                void'(queue_expected(kind, d));
            end
            offer_beat(kind, d);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: addr = 8'h00;
                1: addr = 8'hFF;
                3: addr = ADDR_RESET;
                default: addr = 8'($urandom_range(0, 255));
            endcase
            write_address(addr);
            idle_on = (ph != 4);
            if (ph == 0) hold_req = 1'b1;
            if (ph == 1) send_frame(1'b1);
            start  = result_beats;
            paused = 1'b0;
            while (result_beats - start < PHASE_BEATS) begin
                send_frame(1'b0);
                if (!paused && result_beats - start >= PHASE_BEATS / 2) begin
                    wait_results();
                    paused = 1'b1;
                end
            end
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        if (pending.size() != 0)
            report_mismatch("results never arrived", 16'(pending.size()), 16'h0);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #(12 * 300000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mbrx_pkg.sv
rtl/mbrx_fifo.sv
rtl/mbrx_front.sv
rtl/mbrx_back.sv
rtl/modbus_rtu_frame_receiver_unit.sv
rtl/mbrx_checker.sv
test/tb.sv
